// File: src/qpq_pkg.sv
// ----------------------------------------------------------------------------
// qpq_pkg
// shared types and constants for the priority ordered process queues:
// request and response items, entry layout, controller/datapath interface
// ----------------------------------------------------------------------------
package qpq_pkg;

	// default sizing
	localparam int PROC_SLOTS_DEF    = 32;
	localparam int QUEUE_COUNT_DEF   = 8;
	localparam int PRIORITY_BITS_DEF = 8;

	// fixed field widths
	localparam int ID_W  = 5;
	localparam int PRI_W = 8;

	// request codes
	typedef enum logic [2:0] {
		OP_CLEAR  = 3'd0,
		OP_INSERT = 3'd1,
		OP_PEEK   = 3'd2,
		OP_POP    = 3'd3,
		OP_REMOVE = 3'd4
	} op_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]       req_type;
		logic [2:0]       queue_sel;
		logic [ID_W-1:0]  proc_id;
		logic [PRI_W-1:0] proc_priority;
	} req_t;

	typedef struct packed {
		status_t          status;
		logic [ID_W-1:0]  out_id;
		logic [PRI_W-1:0] out_priority;
		logic             now_empty;
	} rsp_t;

	// one stored queue entry
	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [PRI_W-1:0] pri;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic load_req;
		logic setup;
		logic prime;
		logic fwd_step;
		logic bwd_step;
		logic put;
		logic emit;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic q_bad;
		logic len_zero;
		logic len_full;
		logic is_insert;
		logic is_walk;
		logic fwd_done;
		logic bwd_done;
		logic out_free;
	} dp_sts_t;

endpackage

// File: src/qpq_ram.sv
// ----------------------------------------------------------------------------
// qpq_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module qpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: src/qpq_ctrl.sv
// ----------------------------------------------------------------------------
// qpq_ctrl
// request sequencer: length lookup, entry walk forwards or backwards,
// final insert write and hand-off to the output register
// ----------------------------------------------------------------------------
module qpq_ctrl
	import qpq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	input  dp_sts_t sts,
	output dp_cmd_t cmd,
	output logic    idle
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_LEN   = 7'b0000010,
		S_PRIME = 7'b0000100,
		S_FWD   = 7'b0001000,
		S_BWD   = 7'b0010000,
		S_PUT   = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load_req = 1'b1;
					state_nxt    = S_LEN;
				end
			end
			S_LEN: begin
				cmd.setup = 1'b1;
				if (sts.q_bad) begin
					state_nxt = S_DONE;
				end else if (sts.is_insert) begin
					if (sts.len_full) begin
						state_nxt = S_DONE;
					end else if (sts.len_zero) begin
						state_nxt = S_PUT;
					end else begin
						state_nxt = S_PRIME;
					end
				end else if (sts.is_walk && !sts.len_zero) begin
					state_nxt = S_PRIME;
				end else begin
					state_nxt = S_DONE;
				end
			end
			S_PRIME: begin
				cmd.prime = 1'b1;
				state_nxt = sts.is_insert ? S_BWD : S_FWD;
			end
			S_FWD: begin
				cmd.fwd_step = 1'b1;
				if (sts.fwd_done) begin
					state_nxt = S_DONE;
				end
			end
			S_BWD: begin
				cmd.bwd_step = 1'b1;
				if (sts.bwd_done) begin
					state_nxt = S_PUT;
				end
			end
			S_PUT: begin
				cmd.put   = 1'b1;
				state_nxt = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign idle = (state_q == S_IDLE);

endmodule

// File: src/qpq_datapath.sv
// ----------------------------------------------------------------------------
// qpq_datapath
// request register, queue length store, entry store with one-entry-per-cycle
// shift walk, result registers and output register
// ----------------------------------------------------------------------------
module qpq_datapath
	import qpq_pkg::*;
#(
	parameter int PROC_SLOTS    = PROC_SLOTS_DEF,
	parameter int QUEUE_COUNT   = QUEUE_COUNT_DEF,
	parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  req_t    req,
	input  dp_cmd_t cmd,
	output dp_sts_t sts,
	input  logic    rsp_stall,
	output logic    rsp_valid,
	output rsp_t    rsp
);

	localparam int SLOT_W    = $clog2(PROC_SLOTS);
	localparam int LEN_W     = $clog2(PROC_SLOTS + 1);
	localparam int QSEL_W    = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
	localparam int ENT_DEPTH = QUEUE_COUNT * PROC_SLOTS;
	localparam int ENT_AW    = (ENT_DEPTH > 1) ? $clog2(ENT_DEPTH) : 1;
	localparam int PRI_KEEP  = (PRIORITY_BITS < PRI_W) ? PRIORITY_BITS : PRI_W;
	localparam logic [PRI_W-1:0] PRI_MASK = PRI_W'((64'd1 << PRI_KEEP) - 64'd1);

	function automatic logic [ENT_AW-1:0] ent_addr(input logic [QSEL_W-1:0] q,
	                                               input logic [SLOT_W-1:0] s);
		ent_addr = ENT_AW'(ENT_AW'(q) * ENT_AW'(PROC_SLOTS)) + ENT_AW'(s);
	endfunction

	req_t             req_q;
	logic [LEN_W-1:0] len_q;
	logic [SLOT_W-1:0] idx_q;
	logic             found_q;
	status_t          res_status_q;
	logic [ID_W-1:0]  res_id_q;
	logic [PRI_W-1:0] res_pri_q;
	logic             res_empty_q;
	logic             out_valid_q;
	rsp_t             out_q;
	logic [QUEUE_COUNT-1:0] len_vld_q;

	logic [QSEL_W-1:0] q_idx;
	logic             q_bad;
	logic [LEN_W-1:0] len_rd;
	logic [LEN_W-1:0] n_rd;
	logic             len_zero;
	logic             len_full;
	logic             len_we;
	logic [LEN_W-1:0] len_wdata;

	logic [ENT_AW-1:0] ent_raddr;
	logic [ENT_AW-1:0] ent_waddr;
	logic              ent_we;
	entry_t            ent_wdata;
	logic [ID_W+PRI_W-1:0] ent_rd;
	entry_t            rd_e;

	logic [PRI_W-1:0] new_pri;
	logic             op_insert;
	logic             op_peek;
	logic             op_head;
	logic             op_walk;
	logic             op_clear;
	logic             op_remove;
	logic             hit;
	logic             hit_now;
	logic             any_hit;
	logic             fwd_done;
	logic             bwd_stop;
	logic             bwd_first;
	logic [SLOT_W-1:0] idx_inc;
	logic [SLOT_W-1:0] idx_dec;
	status_t          setup_status;

	// request decode
	always_comb begin
		op_clear  = (req_q.req_type == OP_CLEAR);
		op_insert = (req_q.req_type == OP_INSERT);
		op_peek   = (req_q.req_type == OP_PEEK);
		op_remove = (req_q.req_type == OP_REMOVE);
		op_head   = req_q.req_type inside {OP_PEEK, OP_POP};
		op_walk   = req_q.req_type inside {OP_PEEK, OP_POP, OP_REMOVE};
	end

	assign q_idx    = QSEL_W'(req_q.queue_sel);
	assign q_bad    = (32'(req_q.queue_sel) >= QUEUE_COUNT);
	assign n_rd     = (!q_bad && len_vld_q[q_idx]) ? len_rd : '0;
	assign len_zero = (n_rd == '0);
	assign len_full = (n_rd == LEN_W'(PROC_SLOTS));
	assign new_pri  = req_q.proc_priority & PRI_MASK;

	// walk helpers
	assign rd_e      = entry_t'(ent_rd);
	assign hit       = op_head ? (idx_q == '0) : (rd_e.id == req_q.proc_id);
	assign hit_now   = !found_q && hit;
	assign any_hit   = found_q || hit_now;
	assign fwd_done  = ((LEN_W'(idx_q) + LEN_W'(1)) == len_q) || op_peek;
	assign bwd_stop  = (rd_e.pri >= new_pri);
	assign bwd_first = (idx_q == '0);
	assign idx_inc   = (idx_q == SLOT_W'(PROC_SLOTS - 1)) ? idx_q : idx_q + SLOT_W'(1);
	assign idx_dec   = bwd_first ? idx_q : idx_q - SLOT_W'(1);

	always_comb begin
		if (q_bad) begin
			setup_status = ST_EMPTY;
		end else if (op_insert && len_full) begin
			setup_status = ST_FULL;
		end else if (op_head && len_zero) begin
			setup_status = ST_EMPTY;
		end else if (op_remove && len_zero) begin
			setup_status = ST_NOT_FOUND;
		end else begin
			setup_status = ST_OK;
		end
	end

	// length store write
	always_comb begin
		len_we    = 1'b0;
		len_wdata = '0;
		if (cmd.setup && !q_bad && op_clear) begin
			len_we = 1'b1;
		end else if (cmd.fwd_step && fwd_done && any_hit && !op_peek) begin
			len_we    = 1'b1;
			len_wdata = len_q - LEN_W'(1);
		end else if (cmd.put) begin
			len_we    = 1'b1;
			len_wdata = len_q + LEN_W'(1);
		end
	end

	// entry store ports
	always_comb begin
		ent_raddr = ent_addr(q_idx, idx_q);
		if (cmd.prime) begin
			// first entry of the walk
			ent_raddr = ent_addr(q_idx, idx_q);
		end else if (cmd.fwd_step) begin
			ent_raddr = ent_addr(q_idx, idx_inc);
		end else if (cmd.bwd_step) begin
			ent_raddr = ent_addr(q_idx, idx_dec);
		end
	end

	always_comb begin
		ent_we    = 1'b0;
		ent_waddr = ent_addr(q_idx, idx_q);
		ent_wdata = rd_e;
		if (cmd.fwd_step && found_q) begin
			// close the gap left by the removed entry
			ent_we    = 1'b1;
			ent_waddr = ent_addr(q_idx, idx_q - SLOT_W'(1));
		end else if (cmd.bwd_step && !bwd_stop) begin
			// open a gap towards the tail
			ent_we    = 1'b1;
			ent_waddr = ent_addr(q_idx, idx_inc);
		end else if (cmd.put) begin
			ent_we    = 1'b1;
			ent_wdata = '{id: req_q.proc_id, pri: new_pri};
		end
	end

	qpq_ram #(
		.WIDTH(LEN_W),
		.DEPTH(QUEUE_COUNT)
	) u_len_ram (
		.clk  (clk),
		.we   (len_we),
		.waddr(q_idx),
		.wdata(len_wdata),
		.raddr(QSEL_W'(req.queue_sel)),
		.rdata(len_rd)
	);

	qpq_ram #(
		.WIDTH(ID_W + PRI_W),
		.DEPTH(ENT_DEPTH)
	) u_ent_ram (
		.clk  (clk),
		.we   (ent_we),
		.waddr(ent_waddr),
		.wdata(ent_wdata),
		.raddr(ent_raddr),
		.rdata(ent_rd)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
			len_vld_q   <= '0;
		end else begin
			if (cmd.setup) begin
				found_q <= 1'b0;
			end else if (cmd.fwd_step && hit_now) begin
				found_q <= 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			if (len_we) begin
				len_vld_q[q_idx] <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= req;
		end
		if (cmd.setup) begin
			len_q        <= n_rd;
			idx_q        <= (op_insert && !len_zero) ? SLOT_W'(n_rd - LEN_W'(1)) : '0;
			res_status_q <= setup_status;
			res_id_q     <= '0;
			res_pri_q    <= '0;
			res_empty_q  <= q_bad || op_clear || len_zero;
		end
		if (cmd.fwd_step) begin
			idx_q <= idx_inc;
			if (hit_now) begin
				res_id_q  <= rd_e.id;
				res_pri_q <= rd_e.pri;
			end
			if (fwd_done) begin
				res_status_q <= any_hit ? ST_OK : ST_NOT_FOUND;
				if (any_hit && !op_peek) begin
					res_empty_q <= (len_q == LEN_W'(1));
				end
			end
		end
		if (cmd.bwd_step) begin
			idx_q <= bwd_stop ? idx_inc : idx_dec;
		end
		if (cmd.put) begin
			res_empty_q <= 1'b0;
		end
		if (cmd.emit) begin
			out_q <= '{status: res_status_q, out_id: res_id_q,
			           out_priority: res_pri_q, now_empty: res_empty_q};
		end
	end

	always_comb begin
		sts.q_bad     = q_bad;
		sts.len_zero  = len_zero;
		sts.len_full  = len_full;
		sts.is_insert = op_insert;
		sts.is_walk   = op_walk;
		sts.fwd_done  = fwd_done;
		sts.bwd_done  = bwd_stop || bwd_first;
		sts.out_free  = !out_valid_q || !rsp_stall;
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

// File: src/priority_ordered_process_queues.sv
// ----------------------------------------------------------------------------
// priority_ordered_process_queues
// sequence: clear, refused and empty-queue peek, pop and remove requests pass the
//   length lookup and go to the result; insert, peek, pop and remove may walk the
//   queue first, since the entry ram's single read port walks one entry a cycle
// throughput: one item in flight; the next is taken once the result is loaded
// reset: all queue lengths read as zero and the output is empty; no clear pass
// ----------------------------------------------------------------------------
module priority_ordered_process_queues
	import qpq_pkg::*;
#(
	parameter int PROC_SLOTS    = PROC_SLOTS_DEF,
	parameter int QUEUE_COUNT   = QUEUE_COUNT_DEF,
	parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	// request channel
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	// response channel
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	// command and status between sequencer and datapath
	dp_cmd_t cmd;
	dp_sts_t sts;
	logic    idle;

	// sequencer: one request at a time, walks the queue entry by entry
	qpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.sts      (sts),
		.cmd      (cmd),
		.idle     (idle)
	);

	// datapath: length store, entry store, result and output registers
	qpq_datapath #(
		.PROC_SLOTS   (PROC_SLOTS),
		.QUEUE_COUNT  (QUEUE_COUNT),
		.PRIORITY_BITS(PRIORITY_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (cmd),
		.sts      (sts),
		.rsp_stall(rsp_stall),
		.rsp_valid(rsp_valid),
		.rsp      (rsp)
	);

	// an item is taken only while the sequencer is idle; a finished result
	// waiting in the output register does not hold off the next item
	assign req_stall = !idle;

	// once an item is taken, the next one waits until this one is done
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second item taken while one is in flight");

	// a refused insert leaves a full, hence non-empty, queue
	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_FULL |-> !rsp.now_empty)
		else $error("full status with empty queue");

	// an empty status always comes with an empty queue
	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_EMPTY |-> rsp.now_empty)
		else $error("empty status with non-empty queue");

	// failed lookups return no process
	a_fail_no_payload: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_EMPTY || rsp.status == ST_NOT_FOUND)
		|-> rsp.out_id == '0 && rsp.out_priority == '0)
		else $error("failed request returned a process");

endmodule
